// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cache controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hw/rtl/dmbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmbc_pkg
// Types and constants shared by the block cache controller modules.
// ----------------------------------------------------------------------------
package dmbc_pkg;

    localparam int DEFAULT_MAX_SLOTS = 128;

    localparam int TAG_W      = 31;
    localparam int LBA_W      = 48;
    localparam int SHIFT_W    = 3;
    localparam int SLOT_OUT_W = 7;
    localparam int COUNT_W    = 8;
    localparam int KIND_W     = 2;
    localparam int HASH_MUL   = 251;
    localparam int HASH_DROP  = 8;
    localparam int PROD_W     = TAG_W + HASH_DROP;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = QPTR_W + 1;

    localparam logic [KIND_W-1:0] KIND_HIT       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [LBA_W-1:0]      sector_addr;
        logic [COUNT_W-1:0]    sector_count;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pair;
    } push_ctrl_t;

endpackage

// ===== hw/rtl/dmbc_out_queue.sv =====
// ----------------------------------------------------------------------------
// dmbc_out_queue
// Small result queue: takes one or two results per push, hands them out in
// order on a valid/ready channel.
// ----------------------------------------------------------------------------
module dmbc_out_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dmbc_pkg::push_ctrl_t          ctrl,
    input  dmbc_pkg::result_t             first_item,
    input  dmbc_pkg::result_t             second_item,
    output logic [dmbc_pkg::QFILL_W-1:0]  fill,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dmbc_pkg::result_t             out_item
);
    import dmbc_pkg::*;

    result_t             store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QFILL_W-1:0]  fill_reg;
    logic [QFILL_W-1:0]  fill_next;
    logic [QFILL_W-1:0]  push_count;
    logic                pop;

    assign out_valid = (fill_reg != '0);
    assign out_item  = store_reg[rd_ptr_reg];
    assign fill      = fill_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        push_count = '0;
        if (ctrl.push)
        begin
            push_count = ctrl.pair ? QFILL_W'(2) : QFILL_W'(1);
        end
        wr_ptr_next = wr_ptr_reg + push_count[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        fill_next   = fill_reg + push_count - QFILL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_reg[wr_ptr_reg] <= first_item;
            if (ctrl.pair)
            begin
                store_reg[wr_ptr_reg + QPTR_W'(1)] <= second_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/direct_mapped_block_cache_ctrl.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_block_cache_ctrl
// Tag and dirty bookkeeping for a direct-mapped write-back disk block cache.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: an
//   access (block_id, mark_dirty) or a flush of one slot (flush_slot).
//   Output channel (out_valid/out_ready) returns one or two results per item:
//   a hit, or an optional write-back of a dirty victim followed by a fill
//   read; a flush returns a write-back or "nothing to flush". last marks the
//   final result of an item.
//   Items are not overlapped: the tag RAM is read at the accept edge, the
//   entry is updated and the results queued from the lookup state, and the next
//   item is taken only after that. The first result can be taken once it is queued.
//   Results sit in a 4-entry queue, so a new item is accepted while up to two
//   earlier results wait; when the receiver stalls and the queue cannot take
//   two more results, in_ready drops.
//   After reset the tag RAM is cleared one entry per cycle, all MAX_SLOTS
//   entries, with in_ready low; configuration writes are taken at any time.
//   The sector base and block shift reset to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_block_cache_ctrl #(
    parameter int MAX_SLOTS = dmbc_pkg::DEFAULT_MAX_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [dmbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmbc_pkg::LBA_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [dmbc_pkg::TAG_W-1:0]         block_id,
    input  logic                               mark_dirty,
    input  logic [dmbc_pkg::SLOT_OUT_W-1:0]    flush_slot,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dmbc_pkg::KIND_W-1:0]        kind,
    output logic [dmbc_pkg::SLOT_OUT_W-1:0]    slot,
    output logic [dmbc_pkg::LBA_W-1:0]         sector_addr,
    output logic [dmbc_pkg::COUNT_W-1:0]       sector_count,
    output logic                               last
);
    import dmbc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SLOT_W-1:0]     clr_idx_reg;
    logic [SLOT_W-1:0]     clr_idx_next;

    logic [LBA_W-1:0]      lba_reg;
    logic [SHIFT_W-1:0]    shift_reg;

    // item held for the lookup cycle
    logic                  action_reg;
    logic [TAG_W-1:0]      blk_reg;
    logic                  wr_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_OUT_W-1:0] slot_out_reg;
    logic                  oor_reg;

    entry_t                tag_mem [MAX_SLOTS];
    entry_t                rd_data_reg;

    logic                  accept;
    logic [PROD_W-1:0]     hash_prod;
    logic [SLOT_W-1:0]     hash_idx;
    logic [SLOT_W-1:0]     access_idx;
    logic [SLOT_W+SLOT_OUT_W-1:0] flush_ext;
    logic [SLOT_W+SLOT_OUT_W-1:0] access_ext;
    logic                  flush_oor;
    logic [SLOT_W-1:0]     rd_idx;

    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    entry_t                mem_wdata;
    logic                  look_we;
    entry_t                look_wdata;

    logic                  hit;
    logic [LBA_W-1:0]      addr_tag;
    logic [LBA_W-1:0]      addr_blk;
    logic [COUNT_W-1:0]    count;

    push_ctrl_t            q_ctrl;
    result_t               q_first;
    result_t               q_second;
    result_t               q_item;
    logic [QFILL_W-1:0]    q_fill;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_reg   <= '0;
            shift_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SECTOR_BASE: lba_reg   <= cfg_data;
                CFG_BLOCK_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- index computation at accept ----------------
    assign accept     = in_valid && in_ready;
    assign hash_prod  = PROD_W'(block_id) * PROD_W'(HASH_MUL);
    assign hash_idx   = hash_prod[HASH_DROP +: SLOT_W] & SLOT_W'(MAX_SLOTS - 1);
    assign access_idx = hash_idx >> shift_reg;
    assign access_ext = {{SLOT_OUT_W{1'b0}}, access_idx};
    assign flush_ext  = {{SLOT_W{1'b0}}, flush_slot};
    assign flush_oor  = (32'(flush_slot) >= 32'(MAX_SLOTS));
    assign rd_idx     = (action == ACT_FLUSH) ? flush_ext[SLOT_W-1:0] : access_idx;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= action;
            blk_reg      <= block_id;
            wr_reg       <= mark_dirty;
            idx_reg      <= rd_idx;
            oor_reg      <= (action == ACT_FLUSH) && flush_oor;
            slot_out_reg <= (action == ACT_FLUSH) ? flush_slot
                                                  : access_ext[SLOT_OUT_W-1:0];
        end
    end

    // ---------------- tag RAM ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= tag_mem[rd_idx];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = look_wdata;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_LOOK)
        begin
            mem_we = look_we;
        end
    end

    // ---------------- lookup and update ----------------
    assign hit      = rd_data_reg.valid && (rd_data_reg.tag == blk_reg);
    assign addr_tag = lba_reg + (LBA_W'(rd_data_reg.tag) << shift_reg);
    assign addr_blk = lba_reg + (LBA_W'(blk_reg) << shift_reg);
    assign count    = COUNT_W'(1) << shift_reg;

    always_comb
    begin
        look_we      = 1'b0;
        look_wdata   = rd_data_reg;
        q_ctrl.push  = (state_reg == ST_LOOK);
        q_ctrl.pair  = 1'b0;
        q_first      = '{kind: KIND_NONE, slot: slot_out_reg, sector_addr: '0,
                         sector_count: count, last: 1'b1};
        q_second     = '{kind: KIND_FILL, slot: slot_out_reg, sector_addr: addr_blk,
                         sector_count: count, last: 1'b1};
        if (action_reg == ACT_FLUSH)
        begin
            if (!oor_reg && rd_data_reg.dirty)
            begin
                q_first.kind        = KIND_WRITEBACK;
                q_first.sector_addr = addr_tag;
                look_we             = 1'b1;
                look_wdata.dirty    = 1'b0;
            end
        end
        else if (hit)
        begin
            q_first.kind        = KIND_HIT;
            q_first.sector_addr = addr_blk;
            look_we             = 1'b1;
            look_wdata.dirty    = rd_data_reg.dirty || wr_reg;
        end
        else
        begin
            look_we    = 1'b1;
            look_wdata = '{valid: 1'b1, dirty: wr_reg, tag: blk_reg};
            if (rd_data_reg.valid && rd_data_reg.dirty)
            begin
                // victim write-back goes out ahead of the fill
                q_first.kind        = KIND_WRITEBACK;
                q_first.sector_addr = addr_tag;
                q_first.last        = 1'b0;
                q_ctrl.pair         = 1'b1;
            end
            else
            begin
                q_first = q_second;
            end
        end
    end

    // ---------------- control ----------------
    assign in_ready = (state_reg == ST_IDLE) && (q_fill <= QFILL_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // ---------------- result queue ----------------
    dmbc_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (q_ctrl),
        .first_item  (q_first),
        .second_item (q_second),
        .fill        (q_fill),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (q_item)
    );

    assign kind         = q_item.kind;
    assign slot         = q_item.slot;
    assign sector_addr  = q_item.sector_addr;
    assign sector_count = q_item.sector_count;
    assign last         = q_item.last;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, in_valid && in_ready, state_reg == ST_LOOK)
    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !in_ready)
    `ASSERT_IMPL(a_queue_room, clk, rst_n, state_reg == ST_LOOK, q_fill <= QFILL_W'(QUEUE_DEPTH - 2))
    `ASSERT_IMPL(a_quiet_during_clear, clk, rst_n, state_reg == ST_CLEAR, !out_valid)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the direct-mapped block cache controller. Accesses and slot
// flushes are sent over the input channel under several register settings;
// a scoreboard predicts the hit, write-back, fill and empty-flush results
// and checks every transaction on the output channel in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dmbc_pkg::*;

    localparam int NUM_SLOTS  = DEFAULT_MAX_SLOTS;
    localparam int ALIAS_STEP = 32768;  // block ids this far apart share a slot
    localparam int PHASE_LEN  = 80;

    class block_cache_scoreboard;
        result_t            expected_q[$];
        logic [TAG_W-1:0]   tag_mem[NUM_SLOTS];
        bit                 valid_mem[NUM_SLOTS];
        bit                 dirty_mem[NUM_SLOTS];
        logic [LBA_W-1:0]   sector_base;
        logic [SHIFT_W-1:0] block_shift;
        int                 errors;

        function new();
            sector_base = '0;
            block_shift = '0;
            errors      = 0;
            foreach (valid_mem[i])
            begin
                valid_mem[i] = 1'b0;
                dirty_mem[i] = 1'b0;
                tag_mem[i]   = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LBA_W-1:0] data);
            if (idx == CFG_SECTOR_BASE)
                sector_base = data;
            else
                block_shift = data[SHIFT_W-1:0];
        endfunction

        function logic [SLOT_OUT_W-1:0] slot_of(logic [TAG_W-1:0] blk);
            logic [PROD_W-1:0]     prod;
            logic [SLOT_OUT_W-1:0] hash;
            prod = PROD_W'(blk) * PROD_W'(HASH_MUL);
            hash = SLOT_OUT_W'((prod >> HASH_DROP) & (NUM_SLOTS - 1));
            return hash >> block_shift;
        endfunction

        function logic [LBA_W-1:0] sector_of(logic [TAG_W-1:0] blk);
            return sector_base + (LBA_W'(blk) << block_shift);
        endfunction

        function void push_result(logic [KIND_W-1:0] k, logic [SLOT_OUT_W-1:0] s,
                                  logic [LBA_W-1:0] addr, logic lst);
            result_t r;
            r.kind         = k;
            r.slot         = s;
            r.sector_addr  = addr;
            r.sector_count = COUNT_W'(1 << block_shift);
            r.last         = lst;
            expected_q.push_back(r);
        endfunction

        // Work out the results of one accepted transaction and update the tags.
        function void note_item(logic act, logic [TAG_W-1:0] blk, logic wr,
                                logic [SLOT_OUT_W-1:0] fslot);
            logic [SLOT_OUT_W-1:0] s;
            if (act == ACT_FLUSH)
            begin
                if (dirty_mem[fslot])
                begin
                    push_result(KIND_WRITEBACK, fslot, sector_of(tag_mem[fslot]), 1'b1);
                    dirty_mem[fslot] = 1'b0;
                end
                else
                    push_result(KIND_NONE, fslot, '0, 1'b1);
                return;
            end
            s = slot_of(blk);
            if (valid_mem[s] && tag_mem[s] == blk)
            begin
                if (wr)
                    dirty_mem[s] = 1'b1;
                push_result(KIND_HIT, s, sector_of(blk), 1'b1);
                return;
            end
            if (valid_mem[s] && dirty_mem[s])
                push_result(KIND_WRITEBACK, s, sector_of(tag_mem[s]), 1'b0);
            push_result(KIND_FILL, s, sector_of(blk), 1'b1);
            tag_mem[s]   = blk;
            valid_mem[s] = 1'b1;
            dirty_mem[s] = wr;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d", got.kind, got.slot);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind != want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.slot != want.slot)
            begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.sector_addr != want.sector_addr)
            begin
                $error("sector_addr: expected %h, got %h", want.sector_addr, got.sector_addr);
                errors++;
            end
            if (got.sector_count != want.sector_count)
            begin
                $error("sector_count: expected %0d, got %0d",
                       want.sector_count, got.sector_count);
                errors++;
            end
            if (got.last != want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function void check_drained();
            while (expected_q.size() != 0)
            begin
                $error("missing result: kind %0d slot %0d",
                       expected_q[0].kind, expected_q[0].slot);
                expected_q.pop_front();
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LBA_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  action = ACT_ACCESS;
    logic [TAG_W-1:0]      block_id = '0;
    logic                  mark_dirty = 1'b0;
    logic [SLOT_OUT_W-1:0] flush_slot = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LBA_W-1:0]      sector_addr;
    logic [COUNT_W-1:0]    sector_count;
    logic                  last;

    block_cache_scoreboard sb;
    bit                    idle_on = 1'b1;
    int                    stall_left = 0;
    logic [TAG_W-1:0]      pool[8];

    direct_mapped_block_cache_ctrl dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_id     (block_id),
        .mark_dirty   (mark_dirty),
        .flush_slot   (flush_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .sector_addr  (sector_addr),
        .sector_count (sector_count),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: valid and ready both high here means the transaction
    // completes at the coming rising edge; check it while the outputs are stable.
    always @(negedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind         = kind;
            got.slot         = slot;
            got.sector_addr  = sector_addr;
            got.sector_count = sector_count;
            got.last         = last;
            sb.check_result(got);
        end
    end

    // Choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic program_regs(input logic [LBA_W-1:0] lba, input logic [SHIFT_W-1:0] shift);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SECTOR_BASE;
        cfg_data  <= lba;
        @(posedge clk);
        sb.set_reg(CFG_SECTOR_BASE, lba);
        cfg_index <= CFG_BLOCK_SHIFT;
        cfg_data  <= LBA_W'(shift);
        @(posedge clk);
        sb.set_reg(CFG_BLOCK_SHIFT, LBA_W'(shift));
        cfg_wr_en <= 1'b0;
    endtask

    // Present one transaction and hold it until the block takes it.
    task automatic drive_item(input logic act, input logic [TAG_W-1:0] blk,
                              input logic wr, input logic [SLOT_OUT_W-1:0] fslot);
        logic ready_seen;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        block_id   <= blk;
        mark_dirty <= wr;
        flush_slot <= fslot;
        // sample ready mid-cycle so the edge that takes the transaction is known
        do
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        sb.note_item(act, blk, wr, fslot);
    endtask

    task automatic access_block(input logic [TAG_W-1:0] blk, input logic wr);
        drive_item(ACT_ACCESS, blk, wr, SLOT_OUT_W'($urandom));
    endtask

    task automatic flush_one(input logic [SLOT_OUT_W-1:0] fslot);
        drive_item(ACT_FLUSH, TAG_W'($urandom), 1'($urandom), fslot);
    endtask

    // Drop valid and let every expected result come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        logic [TAG_W-1:0] base[2];
        int               pick;
        base[0] = TAG_W'($urandom);
        base[1] = TAG_W'($urandom);
        foreach (pool[i])
            pool[i] = base[i / 4] + TAG_W'((i % 4) * ALIAS_STEP);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                access_block(pool[$urandom_range(0, 7)], 1'($urandom));
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    flush_one(sb.slot_of(pool[$urandom_range(0, 7)]));
                else
                    flush_one(SLOT_OUT_W'($urandom_range(0, NUM_SLOTS - 1)));
            end
            else
                access_block(TAG_W'($urandom), 1'($urandom));
        end
        drain();
    endtask

    initial
    begin
        logic [TAG_W-1:0] top_blk;
        sb = new();
        top_blk = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Address wrap at the top of the sector range, one sector per block.
        program_regs(48'hFFFF_FFFF_FFF0, '0);
        access_block('0, 1'b0);
        access_block('0, 1'b1);
        access_block(TAG_W'(ALIAS_STEP), 1'b1);
        flush_one(sb.slot_of(TAG_W'(ALIAS_STEP)));
        flush_one(sb.slot_of(TAG_W'(ALIAS_STEP)));
        access_block(top_blk, 1'b1);
        access_block(top_blk, 1'b0);
        flush_one(sb.slot_of(top_blk));
        access_block(top_blk - TAG_W'(ALIAS_STEP), 1'b0);
        access_block(top_blk, 1'b1);
        access_block(top_blk - TAG_W'(ALIAS_STEP), 1'b1);
        flush_one(SLOT_OUT_W'(NUM_SLOTS - 1));
        drain();

        // Largest blocks while old entries are still held.
        program_regs('0, SHIFT_W'(7));
        flush_one('0);
        flush_one(SLOT_OUT_W'(NUM_SLOTS - 1));
        access_block('0, 1'b1);
        access_block(TAG_W'(ALIAS_STEP), 1'b1);
        flush_one('0);
        flush_one(SLOT_OUT_W'(5));
        access_block(top_blk, 1'b0);
        access_block(top_blk, 1'b1);
        drain();

        program_regs(LBA_W'({$urandom, $urandom}), '0);
        run_random(PHASE_LEN);
        program_regs('0, SHIFT_W'(7));
        run_random(PHASE_LEN);
        program_regs(LBA_W'({$urandom, $urandom}), SHIFT_W'(3));
        run_random(PHASE_LEN);
        program_regs('1, SHIFT_W'($urandom_range(1, 6)));
        run_random(PHASE_LEN);
        // Closing stretch runs at full rate on both sides.
        idle_on = 1'b0;
        program_regs(LBA_W'({$urandom, $urandom}), SHIFT_W'($urandom));
        run_random(PHASE_LEN);

        sb.check_drained();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== direct_mapped_block_cache_ctrl.f =====
+incdir+hw/rtl
hw/rtl/dmbc_pkg.sv
hw/rtl/dmbc_out_queue.sv
hw/rtl/direct_mapped_block_cache_ctrl.sv
test/tb_top.sv
